// File: rtl/chgw_pkg.sv
// Package for the gift-wrap convex hull block.
// Holds coordinate width, default capacity and the transaction payload types.
// No dependencies.
package chgw_pkg;

    localparam int COORD_BITS     = 10;
    localparam int MAX_POINTS_DEF = 64;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  last_point;
    } t_in_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] hull_x;
        logic [COORD_BITS-1:0] hull_y;
        logic                  last_vertex;
        logic                  overflow;
    } t_out_item;

endpackage

// File: rtl/convex_hull_gift_wrap.sv
// Convex hull by gift wrapping over a loaded point set, top level.
// Point store, scan sequencer and one shared multiply-accumulate unit.
// Depends on chgw_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | sink      | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | source    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// Points load one per cycle. After the point marked last, the start search visits
// each stored point through a fetch state and a test state. Each hull vertex then
// takes one scan of the store, with up to six products per point on the single
// multiplier, plus a state that starts the scan, a state that builds the vertex
// and its output transaction. Input is not ready from the last point until the
// final vertex is taken. Reset is synchronous, active low, and needs no clearing
// pass. A stalled output holds the sequencer.
module convex_hull_gift_wrap #(
    parameter int MAX_POINTS = chgw_pkg::MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  chgw_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output chgw_pkg::t_out_item o_out_item
);

    localparam int CB = chgw_pkg::COORD_BITS;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = CB + 1;
    localparam int PW = 2 * CB + 3;

    typedef enum logic [13:0] {
        S_LOAD   = 14'b00000000000001,
        S_SFETCH = 14'b00000000000010,
        S_STEST  = 14'b00000000000100,
        S_VERT   = 14'b00000000001000,
        S_WFETCH = 14'b00000000010000,
        S_WTEST  = 14'b00000000100000,
        S_WC1    = 14'b00000001000000,
        S_WC2    = 14'b00000010000000,
        S_WD1    = 14'b00000100000000,
        S_WD2    = 14'b00001000000000,
        S_WD3    = 14'b00010000000000,
        S_WD4    = 14'b00100000000000,
        S_WEND   = 14'b01000000000000,
        S_EMIT   = 14'b10000000000000
    } t_state;

    function automatic logic signed [DW-1:0] f_diff(input logic [CB-1:0] a,
                                                    input logic [CB-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_dropped, n_dropped;
    logic [CW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_nout, n_nout;
    logic                   r_have, n_have;
    logic [2*CB-1:0]        r_start, n_start;
    logic [2*CB-1:0]        r_cur, n_cur;
    logic [2*CB-1:0]        r_cand, n_cand;
    logic signed [PW-1:0]   r_acc, n_acc;
    logic signed [PW-1:0]   r_dp, n_dp;
    chgw_pkg::t_out_item    r_out, n_out;
    logic                   r_ovalid, n_ovalid;

    logic [2*CB-1:0]        r_mem [MAX_POINTS];
    logic [2*CB-1:0]        r_pt;

    logic                   w_we;
    logic                   w_adv;
    logic [CW-1:0]          w_idx_inc;
    logic signed [DW-1:0]   w_ma, w_mb;
    logic signed [2*DW-1:0] w_prod;
    logic signed [PW-1:0]   w_prod_ext;
    logic signed [PW-1:0]   w_sum, w_dif;
    logic [CB-1:0]          w_px, w_py, w_cx, w_cy, w_kx, w_ky, w_sx, w_sy;
    logic                   w_better;

    assign w_px = r_pt[2*CB-1:CB];
    assign w_py = r_pt[CB-1:0];
    assign w_cx = r_cur[2*CB-1:CB];
    assign w_cy = r_cur[CB-1:0];
    assign w_kx = r_cand[2*CB-1:CB];
    assign w_ky = r_cand[CB-1:0];
    assign w_sx = r_start[2*CB-1:CB];
    assign w_sy = r_start[CB-1:0];

    assign w_better   = (w_px < w_sx) || ((w_px == w_sx) && (w_py < w_sy));
    assign w_idx_inc  = r_idx + 1'b1;

    // shared multiply-accumulate unit
    assign w_prod     = w_ma * w_mb;
    assign w_prod_ext = PW'(w_prod);
    assign w_sum      = r_acc + w_prod_ext;
    assign w_dif      = r_acc - w_prod_ext;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_idx     = r_idx;
        n_nout    = r_nout;
        n_have    = r_have;
        n_start   = r_start;
        n_cur     = r_cur;
        n_cand    = r_cand;
        n_acc     = r_acc;
        n_dp      = r_dp;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        w_we      = 1'b0;
        w_adv     = 1'b0;
        w_ma      = '0;
        w_mb      = '0;

        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (r_count < CW'(MAX_POINTS)) begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_in_item.last_point) begin
                        n_idx   = '0;
                        n_state = S_SFETCH;
                    end
                end
            end
            S_SFETCH: begin
                n_state = S_STEST;
            end
            S_STEST: begin
                if ((r_idx == '0) || w_better) begin
                    n_start = r_pt;
                end
                n_cur = n_start;
                w_adv = 1'b1;
            end
            S_VERT: begin
                // capacity of the output run reached: close without a scan
                if (r_nout == CW'(MAX_POINTS - 1)) begin
                    n_out    = '{hull_x: w_cx, hull_y: w_cy, last_vertex: 1'b1,
                                 overflow: r_dropped};
                    n_ovalid = 1'b1;
                    n_state  = S_EMIT;
                end else begin
                    n_idx   = '0;
                    n_have  = 1'b0;
                    n_state = S_WFETCH;
                end
            end
            S_WFETCH: begin
                n_state = S_WTEST;
            end
            S_WTEST: begin
                w_ma = f_diff(w_kx, w_cx);
                w_mb = f_diff(w_py, w_cy);
                if (r_pt == r_cur) begin
                    w_adv = 1'b1;
                end else if (!r_have) begin
                    n_cand = r_pt;
                    n_have = 1'b1;
                    w_adv  = 1'b1;
                end else begin
                    n_acc   = w_prod_ext;
                    n_state = S_WC1;
                end
            end
            S_WC1: begin
                w_ma    = f_diff(w_ky, w_cy);
                w_mb    = f_diff(w_px, w_cx);
                n_acc   = w_dif;
                n_state = S_WC2;
            end
            S_WC2: begin
                w_ma = f_diff(w_px, w_cx);
                w_mb = f_diff(w_px, w_cx);
                if (r_acc[PW-1]) begin
                    n_cand = r_pt;
                    w_adv  = 1'b1;
                end else if (r_acc == '0) begin
                    // collinear: compare squared distances
                    n_acc   = w_prod_ext;
                    n_state = S_WD1;
                end else begin
                    w_adv = 1'b1;
                end
            end
            S_WD1: begin
                w_ma    = f_diff(w_py, w_cy);
                w_mb    = f_diff(w_py, w_cy);
                n_acc   = w_sum;
                n_state = S_WD2;
            end
            S_WD2: begin
                w_ma    = f_diff(w_kx, w_cx);
                w_mb    = f_diff(w_kx, w_cx);
                n_dp    = r_acc;
                n_acc   = w_prod_ext;
                n_state = S_WD3;
            end
            S_WD3: begin
                w_ma    = f_diff(w_ky, w_cy);
                w_mb    = f_diff(w_ky, w_cy);
                n_acc   = w_sum;
                n_state = S_WD4;
            end
            S_WD4: begin
                if (r_dp > r_acc) begin
                    n_cand = r_pt;
                end
                w_adv = 1'b1;
            end
            S_WEND: begin
                n_out    = '{hull_x: w_cx, hull_y: w_cy,
                             last_vertex: (!r_have || (r_cand == r_start)),
                             overflow: r_dropped};
                n_ovalid = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_ovalid = 1'b0;
                    n_nout   = r_nout + 1'b1;
                    if (r_out.last_vertex) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_nout    = '0;
                        n_state   = S_LOAD;
                    end else begin
                        n_cur   = r_cand;
                        n_state = S_VERT;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase

        // advance the scan to the next stored point
        if (w_adv) begin
            n_idx = w_idx_inc;
            if (w_idx_inc == r_count) begin
                n_state = (r_state == S_STEST) ? S_VERT : S_WEND;
            end else begin
                n_state = (r_state == S_STEST) ? S_SFETCH : S_WFETCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_idx     <= '0;
            r_nout    <= '0;
            r_have    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_idx     <= n_idx;
            r_nout    <= n_nout;
            r_have    <= n_have;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_cur   <= n_cur;
        r_cand  <= n_cand;
        r_acc   <= n_acc;
        r_dp    <= n_dp;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[IW-1:0]] <= {i_in_item.point_x, i_in_item.point_y};
        end
        r_pt <= r_mem[r_idx[IW-1:0]];
    end

endmodule

// File: rtl/chgw_check.sv
// Port-level checker for the gift-wrap convex hull block, with its bind.
// Depends on chgw_pkg and convex_hull_gift_wrap.
module chgw_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input chgw_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input chgw_pkg::t_out_item o_out_item
);

    // never take a point while a vertex is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output valid");

    // a final point starts the hull walk and closes the input
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_item.last_point) |=> !o_in_ready)
        else $error("input still ready after last point");

    // the final vertex ends the run
    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_item.last_vertex) |=> !o_out_valid)
        else $error("output valid after final vertex");

    // hold a stalled transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled output changed");

endmodule

bind convex_hull_gift_wrap chgw_check u_chgw_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
